FILE: src/pack_frame_check_and_repair_macros.svh
// Assertion helpers for the frame check and repair block.
// Every check is sampled on i_clk and is off while i_rst_n is low.
`ifndef PACK_FRAME_CHECK_AND_REPAIR_MACROS_SVH
`define PACK_FRAME_CHECK_AND_REPAIR_MACROS_SVH

// Same-cycle implication.
`define PFCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PFCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pfcr_pkg.sv
package pfcr_pkg;

    localparam int unsigned POS_W = 5;
    localparam int unsigned TDATA_W = 56;

    // Byte positions within the 32-byte frame
    localparam logic [POS_W-1:0] POS_FIRST      = 5'd0;
    localparam logic [POS_W-1:0] POS_LOW_END    = 5'd7;
    localparam logic [POS_W-1:0] POS_TYPE       = 5'd11;
    localparam logic [POS_W-1:0] POS_HIGH_START = 5'd16;
    localparam logic [POS_W-1:0] POS_CAPACITY   = 5'd16;
    localparam logic [POS_W-1:0] POS_FLAG       = 5'd17;
    localparam logic [POS_W-1:0] POS_STATUS     = 5'd19;
    localparam logic [POS_W-1:0] POS_HIGH_END   = 5'd19;
    localparam logic [POS_W-1:0] POS_CS0        = 5'd20;
    localparam logic [POS_W-1:0] POS_CS2        = 5'd21;
    localparam logic [POS_W-1:0] POS_COUNT_HI   = 5'd26;
    localparam logic [POS_W-1:0] POS_COUNT_LO   = 5'd27;
    localparam logic [POS_W-1:0] POS_LAST       = 5'd31;

    localparam logic [7:0] FAMILY_ID = 8'hF1;
    localparam logic [7:0] HIGH_MASK = 8'hF0;

    // Cause flag bits
    localparam int unsigned CAUSE_CS0  = 0;
    localparam int unsigned CAUSE_CS2  = 1;
    localparam int unsigned CAUSE_FLAG = 2;

    typedef struct packed {
        logic               tlast;
        logic [TDATA_W-1:0] tdata;
    } t_beat;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

endpackage

FILE: src/pack_frame_check_and_repair.sv
// Battery status frame check and repair. Takes a 32-byte frame one byte per
// transaction (frame_start in s_axis_tuser restarts at byte 0; without it the
// position wraps after byte 31) and returns one repaired byte per byte: nibble
// 34 cleared, nibble 41 rewritten with CS0 (4-bit sum of nibbles 0..15) and
// nibble 43 with CS2 (4-bit sum of nibbles 32..40 after the clear). The result
// for byte 31 carries tlast and the verdict: the three lock causes judged on
// the original frame, the family check and the decoded fields; on other bytes
// those fields read zero. The repair is applied whatever byte 0 holds.
// Rate: one byte per clock sustained while results are taken. The running sums
// are updated in the accepting cycle and the result lands in a two-deep
// output register, so a stalled result does not stop the next byte going in;
// s_axis_tready drops only once both output slots are full, and is held low
// while i_rst_n is low.
module pack_frame_check_and_repair (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] frame_byte
    input  logic [0:0]                        s_axis_tuser,  // [0] frame_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] repaired_byte, [8] cs0_bad, [9] cs2_bad, [10] flag34_set,
    // [11] lock_any, [12] family_match, [20:13] pack_kind,
    // [28:21] capacity_tenths, [36:29] status_byte, [37] fail_locked,
    // [49:38] cycle_total, [55:50] zero
    output logic [pfcr_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast   // frame_done
);

    `include "pack_frame_check_and_repair_macros.svh"

    // Frame state
    logic [pfcr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [3:0]  r_sum_lo, n_sum_lo;     // nibbles 0..15
    logic [3:0]  r_sum_ho, n_sum_ho;     // nibbles 32..40, as received
    logic [3:0]  r_sum_hr, n_sum_hr;     // nibbles 32..40, nibble 34 cleared
    logic [2:0]  r_cause, n_cause;
    logic        r_family, n_family;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_cap, n_cap;
    logic [7:0]  r_status, n_status;
    logic        r_fail, n_fail;
    logic [11:0] r_count, n_count;

    // Output slots
    logic            r_out_v, r_skid_v;
    pfcr_pkg::t_beat r_out, r_skid;

    logic                       w_in_fire, w_out_fire;
    logic [pfcr_pkg::POS_W-1:0] w_pos;
    logic [3:0]                 w_lo, w_hi;
    logic                       w_first;
    logic [7:0]                 w_rb;
    pfcr_pkg::t_beat            w_beat;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    assign w_pos   = s_axis_tuser[0] ? pfcr_pkg::POS_FIRST : r_pos;
    assign w_lo    = s_axis_tdata[3:0];
    assign w_hi    = s_axis_tdata[7:4];
    assign w_first = (w_pos == pfcr_pkg::POS_FIRST);

    // Per-byte update: sums restart on byte 0, holds persist across frames
    always_comb begin
        n_pos    = 5'(w_pos + 5'd1);
        n_sum_lo = w_first ? 4'd0 : r_sum_lo;
        n_sum_ho = w_first ? 4'd0 : r_sum_ho;
        n_sum_hr = w_first ? 4'd0 : r_sum_hr;
        n_cause  = w_first ? 3'd0 : r_cause;
        n_family = w_first ? (s_axis_tdata == pfcr_pkg::FAMILY_ID) : r_family;
        n_type   = r_type;
        n_cap    = r_cap;
        n_status = r_status;
        n_fail   = r_fail;
        n_count  = r_count;
        w_rb     = s_axis_tdata;

        priority if (w_pos <= pfcr_pkg::POS_LOW_END) begin
            n_sum_lo = 4'(n_sum_lo + w_lo + w_hi);
        end else if (w_pos >= pfcr_pkg::POS_HIGH_START &&
                     w_pos <= pfcr_pkg::POS_HIGH_END) begin
            n_sum_ho = 4'(n_sum_ho + w_lo + w_hi);
            if (w_pos == pfcr_pkg::POS_FLAG) begin
                // nibble 34 is dropped from the repaired sum and cleared
                n_sum_hr = 4'(n_sum_hr + w_hi);
                if (w_lo != 4'd0) begin
                    n_cause[pfcr_pkg::CAUSE_FLAG] = 1'b1;
                end
                w_rb = s_axis_tdata & pfcr_pkg::HIGH_MASK;
            end else begin
                n_sum_hr = 4'(n_sum_hr + w_lo + w_hi);
            end
        end else if (w_pos == pfcr_pkg::POS_CS0) begin
            n_sum_ho = 4'(n_sum_ho + w_lo);
            n_sum_hr = 4'(n_sum_hr + w_lo);
            if (w_hi != r_sum_lo) begin
                n_cause[pfcr_pkg::CAUSE_CS0] = 1'b1;
            end
            n_fail = (w_lo != 4'd0);
            w_rb   = {r_sum_lo, w_lo};
        end else if (w_pos == pfcr_pkg::POS_CS2) begin
            if (w_hi != r_sum_ho) begin
                n_cause[pfcr_pkg::CAUSE_CS2] = 1'b1;
            end
            w_rb = {r_sum_hr, w_lo};
        end else begin
            w_rb = s_axis_tdata;
        end

        if (w_pos == pfcr_pkg::POS_TYPE) begin
            n_type = pfcr_pkg::swap_nibbles(s_axis_tdata);
        end
        if (w_pos == pfcr_pkg::POS_CAPACITY) begin
            n_cap = pfcr_pkg::swap_nibbles(s_axis_tdata);
        end
        if (w_pos == pfcr_pkg::POS_STATUS) begin
            n_status = s_axis_tdata;
        end
        if (w_pos == pfcr_pkg::POS_COUNT_HI) begin
            n_count = {w_hi, 8'd0};
        end
        if (w_pos == pfcr_pkg::POS_COUNT_LO) begin
            n_count = {r_count[11:8], pfcr_pkg::swap_nibbles(s_axis_tdata)};
        end
    end

    // Result beat; verdict only on the last byte (nothing updates on it)
    always_comb begin
        w_beat.tlast = (w_pos == pfcr_pkg::POS_LAST);
        w_beat.tdata = {{(pfcr_pkg::TDATA_W - 8){1'b0}}, w_rb};
        if (w_beat.tlast) begin
            w_beat.tdata = {6'd0, r_count, r_fail, r_status, r_cap, r_type, r_family,
                            (r_cause != 3'd0),
                            r_cause[pfcr_pkg::CAUSE_FLAG],
                            r_cause[pfcr_pkg::CAUSE_CS2],
                            r_cause[pfcr_pkg::CAUSE_CS0],
                            w_rb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum_lo <= '0;
            r_sum_ho <= '0;
            r_sum_hr <= '0;
            r_cause  <= '0;
            r_family <= 1'b0;
            r_type   <= '0;
            r_cap    <= '0;
            r_status <= '0;
            r_fail   <= 1'b0;
            r_count  <= '0;
        end else if (w_in_fire) begin
            r_pos    <= n_pos;
            r_sum_lo <= n_sum_lo;
            r_sum_ho <= n_sum_ho;
            r_sum_hr <= n_sum_hr;
            r_cause  <= n_cause;
            r_family <= n_family;
            r_type   <= n_type;
            r_cap    <= n_cap;
            r_status <= n_status;
            r_fail   <= n_fail;
            r_count  <= n_count;
        end
    end

    // Two-slot output: the skid slot catches a byte while the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_fire || !r_out_v) begin
            r_out_v  <= r_skid_v || w_in_fire;
            r_skid_v <= 1'b0;
        end else if (w_in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : w_beat;
        end else if (w_in_fire) begin
            r_skid <= w_beat;
        end
    end

    assign s_axis_tready = i_rst_n && !r_skid_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out.tdata;
    assign m_axis_tlast  = r_out.tlast;

    `PFCR_ASSERT_NOW(a_skid_behind_out, r_skid_v, r_out_v,
        "skid slot full while output slot empty")
    `PFCR_ASSERT_NOW(a_no_verdict_mid_frame, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[pfcr_pkg::TDATA_W-1:8] == '0,
        "verdict fields set on a byte other than the last")
    `PFCR_ASSERT_NOW(a_lock_is_or, m_axis_tvalid,
        m_axis_tdata[11] == (m_axis_tdata[8] || m_axis_tdata[9] || m_axis_tdata[10]),
        "lock_any disagrees with its causes")
    `PFCR_ASSERT_NEXT(a_start_restarts, w_in_fire && s_axis_tuser[0],
        r_pos == 5'd1, "frame start did not restart the byte position")

endmodule

FILE: bench/pack_frame_check_and_repair_tb.sv
module pack_frame_check_and_repair_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest run of cycles with no transaction on either side before the run is
    // called hung. The worst correct stretch is one long sender gap plus one long
    // receiver stall, so this is ample.
    localparam int unsigned HANG_LIMIT   = 2000;
    localparam int unsigned TARGET_BYTES = 1550;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One result transaction, field by field
    typedef struct packed {
        logic [5:0]  pad;
        logic [11:0] cycle_total;
        logic        fail_locked;
        logic [7:0]  status_byte;
        logic [7:0]  capacity_tenths;
        logic [7:0]  pack_kind;
        logic        family_match;
        logic        lock_any;
        logic        flag34_set;
        logic        cs2_bad;
        logic        cs0_bad;
        logic        frame_done;
        logic [7:0]  repaired_byte;
    } t_frame_result;

    // Directed row: frame_start, frame_byte, and a hand-written repaired byte
    // where one is obvious (frame_done is low on all of these rows)
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       typed;
        logic [7:0] want_byte;
    } t_stim_row;

    localparam int unsigned N_DIRECTED = 24;
    localparam t_stim_row DIRECTED [0:N_DIRECTED-1] = '{
        '{1'b1, 8'hFF, 1'b1, 8'hFF},   // all ones straight after reset
        '{1'b0, 8'h00, 1'b1, 8'h00},   // all zeros
        '{1'b1, 8'hF1, 1'b1, 8'hF1},   // restart mid-frame, family id in byte 0
        '{1'b0, 8'h12, 1'b0, 8'h00},
        '{1'b0, 8'h34, 1'b0, 8'h00},
        '{1'b0, 8'h56, 1'b0, 8'h00},
        '{1'b0, 8'h78, 1'b0, 8'h00},
        '{1'b0, 8'h9A, 1'b0, 8'h00},
        '{1'b0, 8'hBC, 1'b0, 8'h00},
        '{1'b0, 8'hDE, 1'b0, 8'h00},   // end of the CS0 block
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h5A, 1'b0, 8'h00},   // pack kind byte
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h00, 1'b0, 8'h00},
        '{1'b0, 8'h3C, 1'b0, 8'h00},   // capacity byte, start of CS2 block
        '{1'b0, 8'hFF, 1'b1, 8'hF0},   // lock flag nibble cleared
        '{1'b0, 8'h80, 1'b0, 8'h00},
        '{1'b0, 8'h7E, 1'b0, 8'h00},   // status byte
        '{1'b0, 8'hA5, 1'b0, 8'h00},   // CS0 nibble rewritten
        '{1'b0, 8'h5A, 1'b0, 8'h00}    // CS2 nibble rewritten
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;   // [7:0] frame_byte
    logic [0:0]          s_axis_tuser  = '0;   // [0] frame_start
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] repaired_byte, [8] cs0_bad, [9] cs2_bad, [10] flag34_set,
    // [11] lock_any, [12] family_match, [20:13] pack_kind,
    // [28:21] capacity_tenths, [36:29] status_byte, [37] fail_locked,
    // [49:38] cycle_total, [55:50] zero
    logic [pfcr_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;   // frame_done

    // Predictor state, a copy of the block's own registers
    logic [pfcr_pkg::POS_W-1:0] pred_pos;
    logic [3:0]       pred_sum_low;
    logic [3:0]       pred_sum_high_orig;
    logic [3:0]       pred_sum_high_rep;
    logic [2:0]       pred_causes;
    logic             pred_family;
    logic [7:0]       pred_type;
    logic [7:0]       pred_capacity;
    logic [7:0]       pred_status;
    logic             pred_fail;
    logic [11:0]      pred_count;

    t_frame_result pending_repairs [$];
    int            error_count  = 0;
    int            bytes_sent   = 0;
    int            idle_cycles  = 0;
    int            sink_left    = 0;
    bit            no_gaps      = 1'b0;   // burst stretch: neither side idles

    pack_frame_check_and_repair u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, the odd long one
    function automatic int gap_len();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Works out the repaired byte and, on byte 31, the verdict for one byte
    task automatic predict_repaired_byte(input logic [7:0] b, input logic start,
                                         output t_frame_result res);
        logic [pfcr_pkg::POS_W-1:0] pos;
        logic [3:0]       lo;
        logic [3:0]       hi;
        lo  = b[3:0];
        hi  = b[7:4];
        pos = start ? pfcr_pkg::POS_FIRST : pred_pos;
        res = '0;
        res.repaired_byte = b;

        if (pos == pfcr_pkg::POS_FIRST) begin
            pred_sum_low       = '0;
            pred_sum_high_orig = '0;
            pred_sum_high_rep  = '0;
            pred_causes        = '0;
            pred_family        = (b == pfcr_pkg::FAMILY_ID);
        end

        if (pos <= pfcr_pkg::POS_LOW_END) begin
            pred_sum_low = pred_sum_low + lo + hi;
        end else if (pos >= pfcr_pkg::POS_HIGH_START && pos <= pfcr_pkg::POS_HIGH_END) begin
            pred_sum_high_orig = pred_sum_high_orig + lo + hi;
            if (pos == pfcr_pkg::POS_FLAG) begin
                // nibble 34 is low nibble here: cleared, and left out of CS2
                pred_sum_high_rep = pred_sum_high_rep + hi;
                if (lo != 4'h0) begin
                    pred_causes[pfcr_pkg::CAUSE_FLAG] = 1'b1;
                end
                res.repaired_byte = b & pfcr_pkg::HIGH_MASK;
            end else begin
                pred_sum_high_rep = pred_sum_high_rep + lo + hi;
            end
        end else if (pos == pfcr_pkg::POS_CS0) begin
            pred_sum_high_orig = pred_sum_high_orig + lo;
            pred_sum_high_rep  = pred_sum_high_rep + lo;
            if (hi != pred_sum_low) begin
                pred_causes[pfcr_pkg::CAUSE_CS0] = 1'b1;
            end
            pred_fail = (lo != 4'h0);
            res.repaired_byte = {pred_sum_low, lo};
        end else if (pos == pfcr_pkg::POS_CS2) begin
            if (hi != pred_sum_high_orig) begin
                pred_causes[pfcr_pkg::CAUSE_CS2] = 1'b1;
            end
            res.repaired_byte = {pred_sum_high_rep, lo};
        end

        if (pos == pfcr_pkg::POS_TYPE)     pred_type     = {lo, hi};
        if (pos == pfcr_pkg::POS_CAPACITY) pred_capacity = {lo, hi};
        if (pos == pfcr_pkg::POS_STATUS)   pred_status   = b;
        if (pos == pfcr_pkg::POS_COUNT_HI) pred_count    = {hi, 8'h00};
        if (pos == pfcr_pkg::POS_COUNT_LO) pred_count[7:0] = {lo, hi};

        if (pos == pfcr_pkg::POS_LAST) begin
            res.frame_done      = 1'b1;
            res.cs0_bad         = pred_causes[pfcr_pkg::CAUSE_CS0];
            res.cs2_bad         = pred_causes[pfcr_pkg::CAUSE_CS2];
            res.flag34_set      = pred_causes[pfcr_pkg::CAUSE_FLAG];
            res.lock_any        = |pred_causes;
            res.family_match    = pred_family;
            res.pack_kind       = pred_type;
            res.capacity_tenths = pred_capacity;
            res.status_byte     = pred_status;
            res.fail_locked     = pred_fail;
            res.cycle_total     = pred_count;
        end
        pred_pos = pos + 5'd1;   // wraps after byte 31
    endtask

    // One input transaction: optional gap, then hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic start,
                             input logic typed, input logic [7:0] want_byte);
        int            gap;
        t_frame_result res;
        gap = gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_repaired_byte(b, start, res);
        if (typed) begin
            res = '0;
            res.repaired_byte = want_byte;
        end
        pending_repairs.push_back(res);
        bytes_sent++;
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Stimulus
    initial begin
        logic [7:0] frame [0:31];
        logic [3:0] sum;
        int         kind;
        int         len;
        logic       start;

        pred_pos = '0;  pred_sum_low = '0;  pred_sum_high_orig = '0;
        pred_sum_high_rep = '0;  pred_causes = '0;  pred_family = 1'b0;
        pred_type = '0;  pred_capacity = '0;  pred_status = '0;
        pred_fail = 1'b0;  pred_count = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].typed,
                      DIRECTED[i].want_byte);
        end

        // Random part: mostly whole frames with random content, the checksum
        // nibbles and flag nibble often made consistent so that clean frames
        // turn up too; mixed in at random with cut-short frames and plain noise.
        while (bytes_sent < TARGET_BYTES) begin
            no_gaps = ($urandom_range(0, 9) == 0);
            kind    = $urandom_range(0, 99);
            for (int i = 0; i < 32; i++) begin
                frame[i] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 1) == 0) frame[0] = pfcr_pkg::FAMILY_ID;
            if ($urandom_range(0, 1) == 0) frame[pfcr_pkg::POS_FLAG][3:0] = 4'h0;
            sum = '0;
            for (int i = 0; i <= int'(pfcr_pkg::POS_LOW_END); i++) begin
                sum = sum + frame[i][3:0] + frame[i][7:4];
            end
            if ($urandom_range(0, 4) < 3) frame[pfcr_pkg::POS_CS0][7:4] = sum;
            sum = '0;
            for (int i = int'(pfcr_pkg::POS_HIGH_START);
                 i <= int'(pfcr_pkg::POS_HIGH_END); i++) begin
                sum = sum + frame[i][3:0] + frame[i][7:4];
            end
            sum = sum + frame[pfcr_pkg::POS_CS0][3:0];
            if ($urandom_range(0, 4) < 3) frame[pfcr_pkg::POS_CS2][7:4] = sum;

            if (kind < 90) begin
                // whole frame, or one cut short and abandoned
                len = (kind < 75) ? 32 : $urandom_range(1, 31);
                // at byte 0 already: may rely on the wrap rather than a start
                start = (pred_pos != pfcr_pkg::POS_FIRST) || ($urandom_range(0, 1) == 0);
                for (int i = 0; i < len; i++) begin
                    send_byte(frame[i], (i == 0) ? start : 1'b0, 1'b0, 8'h00);
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    send_byte(frame[i], ($urandom_range(0, 3) == 0), 1'b0, 8'h00);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;

        while (pending_repairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver back-pressure: runs of ready broken by stalls of random length
    always @(posedge i_clk) begin
        if (sink_left != 0) begin
            sink_left <= sink_left - 1;
        end else if (m_axis_tready) begin
            if (gap_len() != 0) begin
                m_axis_tready <= 1'b0;
                sink_left     <= gap_len();
            end else begin
                sink_left <= $urandom_range(0, 30);
            end
        end else begin
            m_axis_tready <= 1'b1;
            sink_left     <= $urandom_range(0, 30);
        end
    end

    // Result checking against the oldest expectation
    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            // frame_done sits between the repaired byte and the verdict bits
            got = t_frame_result'({m_axis_tdata[pfcr_pkg::TDATA_W-1:8], m_axis_tlast,
                                   m_axis_tdata[7:0]});
            if (pending_repairs.size() == 0) begin
                $error("result transaction with nothing pending: tdata %0h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_repairs.pop_front();
                check_field("repaired_byte",   12'(want.repaired_byte),
                            12'(got.repaired_byte));
                check_field("frame_done",      12'(want.frame_done), 12'(got.frame_done));
                check_field("cs0_bad",         12'(want.cs0_bad),    12'(got.cs0_bad));
                check_field("cs2_bad",         12'(want.cs2_bad),    12'(got.cs2_bad));
                check_field("flag34_set",      12'(want.flag34_set), 12'(got.flag34_set));
                check_field("lock_any",        12'(want.lock_any),   12'(got.lock_any));
                check_field("family_match",    12'(want.family_match),
                            12'(got.family_match));
                check_field("pack_kind",       12'(want.pack_kind),  12'(got.pack_kind));
                check_field("capacity_tenths", 12'(want.capacity_tenths),
                            12'(got.capacity_tenths));
                check_field("status_byte",     12'(want.status_byte),
                            12'(got.status_byte));
                check_field("fail_locked",     12'(want.fail_locked),
                            12'(got.fail_locked));
                check_field("cycle_total",     want.cycle_total,     got.cycle_total);
                check_field("tdata padding",   12'(want.pad),        12'(got.pad));
            end
        end
    end

    // Hang detection: cycles since the last transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= HANG_LIMIT) begin
                $error("no transaction for %0d cycles, %0d results outstanding",
                       HANG_LIMIT, pending_repairs.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
